### design/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// Shared constants and controller/datapath interface types for the
// longest increasing subsequence block.
// ----------------------------------------------------------------------------
package lis_pkg;

    // Default sizing
    localparam int LIS_MAX_LEN    = 64;
    localparam int LIS_VALUE_BITS = 16;

    // Fixed port widths
    localparam int VALUE_W    = 16;
    localparam int INDEX_W    = 6;
    localparam int RUN_W      = 7;
    localparam int UNSORTED_W = 6;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;     // latch the incoming key and last flag
        logic scan_init;  // restart the compare scan
        logic scan_run;   // one scan step over stored elements
        logic store;      // write the new element and update the best run
        logic ovf_set;    // record a dropped input
        logic walk_init;  // mark the chosen end, start the backward walk
        logic walk_run;   // one backward walk step
        logic emit_init;  // restart the emission pointer
        logic emit_load;  // load the output register
        logic clear;      // return run totals, flags and marks to reset values
    } lis_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic full;        // store holds MAX_LEN elements
        logic final_pend;  // latched item was the last of the sequence
        logic scan_done;   // all compares finished
        logic walk_done;   // backward walk finished
        logic out_taken;   // output transaction this cycle
        logic out_last;    // the pending result is the last one
    } lis_stat_t;

endpackage

### design/lis_ctrl.sv
// ----------------------------------------------------------------------------
// lis_ctrl
// Sequencer for load, compare scan, store, backward walk and emission.
// ----------------------------------------------------------------------------
module lis_ctrl
    import lis_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_final_item,
    output logic      s_ready,
    output lis_cmd_t  cmd,
    input  lis_stat_t stat
);

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_SCAN      = 8'b0000_0010,
        ST_STORE     = 8'b0000_0100,
        ST_MARK      = 8'b0000_1000,
        ST_WALK      = 8'b0001_0000,
        ST_EMIT_RD   = 8'b0010_0000,
        ST_EMIT_OUT  = 8'b0100_0000,
        ST_EMIT_HOLD = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (!stat.full) begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_SCAN;
                    end else begin
                        cmd.ovf_set = 1'b1;
                        if (s_final_item) begin
                            state_next = ST_MARK;
                        end
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store  = 1'b1;
                state_next = stat.final_pend ? ST_MARK : ST_IDLE;
            end
            ST_MARK: begin
                cmd.walk_init = 1'b1;
                state_next    = ST_WALK;
            end
            ST_WALK: begin
                cmd.walk_run = 1'b1;
                if (stat.walk_done) begin
                    cmd.emit_init = 1'b1;
                    state_next    = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                cmd.emit_load = 1'b1;
                state_next    = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD: begin
                if (stat.out_taken) begin
                    if (stat.out_last) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_EMIT_OUT;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/lis_dp.sv
// ----------------------------------------------------------------------------
// lis_dp
// Element stores, compare scan, best-run tracking, backward walk marks and
// the result output register.
// ----------------------------------------------------------------------------
module lis_dp
    import lis_pkg::*;
#(
    parameter int MAX_LEN    = LIS_MAX_LEN,
    parameter int VALUE_BITS = LIS_VALUE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [VALUE_W-1:0]    s_value,
    input  logic                  s_final_item,
    input  lis_cmd_t              cmd,
    output lis_stat_t             stat,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [INDEX_W-1:0]    m_index,
    output logic [RUN_W-1:0]      m_run_length,
    output logic                  m_in_subsequence,
    output logic [RUN_W-1:0]      m_longest,
    output logic [UNSORTED_W-1:0] m_unsorted_count,
    output logic                  m_overflow,
    output logic                  m_final_result
);

    localparam int KEY_W  = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int CNT_W  = $clog2(MAX_LEN + 1);

    // Element stores
    logic [KEY_W-1:0] value_mem [MAX_LEN];
    logic [CNT_W-1:0] length_mem [MAX_LEN];

    // Control registers
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   best_len_reg, best_len_next;
    logic [ADDR_W-1:0]  best_end_reg, best_end_next;
    logic               ovf_reg, ovf_next;
    logic               final_pend_reg, final_pend_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [ADDR_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   best_prev_reg, best_prev_next;
    logic [CNT_W-1:0]   want_reg, want_next;
    logic [MAX_LEN-1:0] marks_reg, marks_next;
    logic               m_valid_reg, m_valid_next;

    // Payload registers
    logic [KEY_W-1:0]      key_reg;
    logic [KEY_W-1:0]      val_q_reg;
    logic [CNT_W-1:0]      len_q_reg;
    logic [INDEX_W-1:0]    out_index_reg;
    logic [RUN_W-1:0]      out_run_reg;
    logic                  out_member_reg;
    logic [RUN_W-1:0]      out_longest_reg;
    logic [UNSORTED_W-1:0] out_unsorted_reg;
    logic                  out_ovf_reg;
    logic                  out_final_reg;

    logic [ADDR_W-1:0] ptr_m1;
    logic [ADDR_W-1:0] rd_addr;
    logic [CNT_W-1:0]  new_len;
    logic              issue;

    assign ptr_m1  = ADDR_W'(ptr_reg - CNT_W'(1));
    assign rd_addr = cmd.walk_run ? ptr_m1 : ptr_reg[ADDR_W-1:0];
    assign new_len = best_prev_reg + CNT_W'(1);

    // Status
    assign stat.full       = (count_reg == CNT_W'(MAX_LEN));
    assign stat.final_pend = final_pend_reg;
    assign stat.scan_done  = (ptr_reg == count_reg) && !rd_valid_reg;
    assign stat.walk_done  = ((ptr_reg == '0) && !rd_valid_reg) ||
                             (want_reg == CNT_W'(1));
    assign stat.out_taken  = m_valid_reg && m_ready;
    assign stat.out_last   = out_final_reg;

    // Element memories: one write port, registered read
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            value_mem[count_reg[ADDR_W-1:0]]  <= key_reg;
            length_mem[count_reg[ADDR_W-1:0]] <= new_len;
        end
        val_q_reg <= value_mem[rd_addr];
        len_q_reg <= length_mem[rd_addr];
    end

    // Next-state logic for scan, store, walk and emission
    always_comb begin
        count_next      = count_reg;
        best_len_next   = best_len_reg;
        best_end_next   = best_end_reg;
        ovf_next        = ovf_reg;
        final_pend_next = final_pend_reg;
        ptr_next        = ptr_reg;
        rd_valid_next   = rd_valid_reg;
        rd_idx_next     = rd_idx_reg;
        best_prev_next  = best_prev_reg;
        want_next       = want_reg;
        marks_next      = marks_reg;
        m_valid_next    = m_valid_reg;
        issue           = 1'b0;

        if (cmd.accept) begin
            final_pend_next = s_final_item;
        end
        if (cmd.ovf_set) begin
            ovf_next = 1'b1;
        end
        if (cmd.scan_init) begin
            ptr_next       = '0;
            rd_valid_next  = 1'b0;
            best_prev_next = '0;
        end

        // Scan: issue reads forward, compare the registered read data in the next cycle
        if (cmd.scan_run) begin
            issue         = (ptr_reg != count_reg);
            rd_valid_next = issue;
            if (issue) begin
                ptr_next = ptr_reg + CNT_W'(1);
            end
            if (rd_valid_reg && (val_q_reg < key_reg) && (len_q_reg > best_prev_reg)) begin
                best_prev_next = len_q_reg;
            end
        end

        // Store the new element; first to reach a new maximum wins
        if (cmd.store) begin
            count_next = count_reg + CNT_W'(1);
            if (new_len > best_len_reg) begin
                best_len_next = new_len;
                best_end_next = count_reg[ADDR_W-1:0];
            end
        end

        // Backward walk from the chosen end
        if (cmd.walk_init) begin
            marks_next[best_end_reg] = 1'b1;
            want_next                = best_len_reg;
            ptr_next                 = CNT_W'(best_end_reg);
            rd_valid_next            = 1'b0;
        end
        if (cmd.walk_run) begin
            issue         = (ptr_reg != '0);
            rd_valid_next = issue;
            rd_idx_next   = ptr_m1;
            if (issue) begin
                ptr_next = ptr_reg - CNT_W'(1);
            end
            if (rd_valid_reg && (want_reg > CNT_W'(1)) &&
                (len_q_reg == want_reg - CNT_W'(1))) begin
                marks_next[rd_idx_reg] = 1'b1;
                want_next              = len_q_reg;
            end
        end

        // Emission
        if (cmd.emit_init) begin
            ptr_next      = '0;
            rd_valid_next = 1'b0;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.emit_load) begin
            m_valid_next = 1'b1;
            ptr_next     = ptr_reg + CNT_W'(1);
        end

        // End of run
        if (cmd.clear) begin
            count_next      = '0;
            best_len_next   = '0;
            best_end_next   = '0;
            ovf_next        = 1'b0;
            final_pend_next = 1'b0;
            marks_next      = '0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            best_len_reg   <= '0;
            best_end_reg   <= '0;
            ovf_reg        <= 1'b0;
            final_pend_reg <= 1'b0;
            ptr_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            rd_idx_reg     <= '0;
            best_prev_reg  <= '0;
            want_reg       <= '0;
            marks_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            count_reg      <= count_next;
            best_len_reg   <= best_len_next;
            best_end_reg   <= best_end_next;
            ovf_reg        <= ovf_next;
            final_pend_reg <= final_pend_next;
            ptr_reg        <= ptr_next;
            rd_valid_reg   <= rd_valid_next;
            rd_idx_reg     <= rd_idx_next;
            best_prev_reg  <= best_prev_next;
            want_reg       <= want_next;
            marks_reg      <= marks_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Key capture and result register
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            key_reg <= s_value[KEY_W-1:0];
        end
        if (cmd.emit_load) begin
            out_index_reg    <= INDEX_W'(ptr_reg[ADDR_W-1:0]);
            out_run_reg      <= RUN_W'(len_q_reg);
            out_member_reg   <= marks_reg[ptr_reg[ADDR_W-1:0]];
            out_longest_reg  <= RUN_W'(best_len_reg);
            out_unsorted_reg <= UNSORTED_W'(count_reg - best_len_reg);
            out_ovf_reg      <= ovf_reg;
            out_final_reg    <= ((ptr_reg + CNT_W'(1)) == count_reg);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_index          = out_index_reg;
    assign m_run_length     = out_run_reg;
    assign m_in_subsequence = out_member_reg;
    assign m_longest        = out_longest_reg;
    assign m_unsorted_count = out_unsorted_reg;
    assign m_overflow       = out_ovf_reg;
    assign m_final_result   = out_final_reg;

endmodule

### design/longest_increasing_subsequence.sv
// ----------------------------------------------------------------------------
// longest_increasing_subsequence
// Loads a sequence, computes the increasing run length ending at each element
// by a quadratic scan, marks one longest subsequence and emits one result per
// stored element after the last input.
//
//   Channel  Ports                                  Direction  Transaction
//   s_       s_value, s_final_item                  in         one element
//   m_       m_index, m_run_length, m_in_subsequence, out      one result
//            m_longest, m_unsorted_count, m_overflow,
//            m_final_result
//
// An element at position p is accepted, then p memory reads go through the
// single read port of the element stores, then their compares, an end-of-scan
// step and the store follow. A dropped element (store full) is only accepted.
// On the last element the mark step and the backward walk from the chosen end
// run, then a read step, then each result is loaded and held until m_ready
// takes it; no input is taken meanwhile.
// aresetn is synchronous, active low, and clears all control state.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence
    import lis_pkg::*;
#(
    parameter int MAX_LEN    = LIS_MAX_LEN,
    parameter int VALUE_BITS = LIS_VALUE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_W-1:0]    s_value,
    input  logic                  s_final_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [INDEX_W-1:0]    m_index,
    output logic [RUN_W-1:0]      m_run_length,
    output logic                  m_in_subsequence,
    output logic [RUN_W-1:0]      m_longest,
    output logic [UNSORTED_W-1:0] m_unsorted_count,
    output logic                  m_overflow,
    output logic                  m_final_result
);

    lis_cmd_t  cmd;
    lis_stat_t stat;

    // Sequencer
    lis_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_final_item (s_final_item),
        .s_ready      (s_ready),
        .cmd          (cmd),
        .stat         (stat)
    );

    // Datapath
    lis_dp #(
        .MAX_LEN    (MAX_LEN),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_value          (s_value),
        .s_final_item     (s_final_item),
        .cmd              (cmd),
        .stat             (stat),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_index          (m_index),
        .m_run_length     (m_run_length),
        .m_in_subsequence (m_in_subsequence),
        .m_longest        (m_longest),
        .m_unsorted_count (m_unsorted_count),
        .m_overflow       (m_overflow),
        .m_final_result   (m_final_result)
    );

    // Loading and emission never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // The last result of a run returns the block to loading
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_final_result) |=> s_ready)
        else $error("block not ready after last result");

    // Datapath steps are exclusive
    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.scan_run, cmd.store, cmd.walk_run, cmd.emit_load, cmd.accept}))
        else $error("conflicting datapath commands");

    // A taken result drops m_valid before the next one is loaded
    a_emit_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> !m_valid)
        else $error("result register reloaded without read cycle");

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for longest_increasing_subsequence. Drives whole
// sequences of elements (directed corner cases, then random sequences of
// several shapes, full and overflowing stores among them) with bursty input
// and a stalling result receiver. A scoreboard runs the quadratic LIS
// computation on every accepted element and checks each result in order.
// ----------------------------------------------------------------------------
module tb;
    import lis_pkg::*;

    localparam int ITEM_TARGET    = 280;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 200;

    // one result transaction, as seen on the m_ ports
    typedef struct packed {
        logic [INDEX_W-1:0]    index;
        logic [RUN_W-1:0]      run_length;
        logic                  in_subsequence;
        logic [RUN_W-1:0]      longest;
        logic [UNSORTED_W-1:0] unsorted_count;
        logic                  overflow;
        logic                  final_result;
    } lis_result_t;

    typedef enum {KEYS_RANDOM, KEYS_FEW, KEYS_NOISY_RAMP, KEYS_RISING, KEYS_FALLING}
        key_shape_t;
    typedef enum {READY_ALWAYS, READY_MOSTLY, READY_RARELY} ready_mode_t;

    // ------------------------------------------------------------------------
    // Scoreboard: LIS predictor plus the queue of results still owed
    // ------------------------------------------------------------------------
    class lis_scoreboard;
        logic [VALUE_W-1:0] keys [LIS_MAX_LEN];
        int unsigned        runs [LIS_MAX_LEN];
        bit                 marks[LIS_MAX_LEN];
        int unsigned        stored;
        int unsigned        best_end;
        int unsigned        best_run;
        bit                 dropped;
        lis_result_t        owed_results[$];
        int                 mismatches;

        function new();
            mismatches = 0;
            clear_run();
        endfunction

        function void clear_run();
            stored   = 0;
            best_end = 0;
            best_run = 0;
            dropped  = 0;
            foreach (marks[i]) marks[i] = 0;
        endfunction

        // accepted element: update the run lengths, emit on the last one
        function void note_element(logic [VALUE_W-1:0] key, logic last);
            int unsigned best_prev;
            int unsigned want;
            int unsigned k;
            lis_result_t r;
            if (stored < LIS_MAX_LEN) begin
                best_prev = 0;
                for (k = 0; k < stored; k++)
                    if (keys[k] < key && runs[k] > best_prev) best_prev = runs[k];
                keys[stored]  = key;
                runs[stored]  = best_prev + 1;
                marks[stored] = 0;
                if (best_prev + 1 > best_run) begin
                    best_run = best_prev + 1;
                    best_end = stored;
                end
                stored++;
            end else begin
                dropped = 1;
            end
            if (!last) return;

            // backward walk from the chosen end, nearest predecessor first
            if (stored > 0) begin
                marks[best_end] = 1;
                want = runs[best_end];
                k = best_end;
                while (k > 0 && want > 1) begin
                    k--;
                    if (runs[k] + 1 == want) begin
                        marks[k] = 1;
                        want = runs[k];
                    end
                end
            end
            for (int i = 0; i < stored; i++) begin
                r.index          = INDEX_W'(i);
                r.run_length     = RUN_W'(runs[i]);
                r.in_subsequence = marks[i];
                r.longest        = RUN_W'(best_run);
                r.unsorted_count = UNSORTED_W'(stored - best_run);
                r.overflow       = dropped;
                r.final_result   = (i + 1 == stored);
                owed_results.push_back(r);
            end
            clear_run();
        endfunction

        function void check_result(lis_result_t got);
            lis_result_t exp_r;
            if (owed_results.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: unexpected result index=%0d run=%0d", $realtime,
                             got.index, got.run_length);
                mismatches++;
                return;
            end
            exp_r = owed_results.pop_front();
            if (got.index !== exp_r.index || got.run_length !== exp_r.run_length ||
                got.in_subsequence !== exp_r.in_subsequence ||
                got.longest !== exp_r.longest ||
                got.unsorted_count !== exp_r.unsorted_count ||
                got.overflow !== exp_r.overflow ||
                got.final_result !== exp_r.final_result) begin
                if (mismatches < 10) begin
                    $display("%0t: mismatch idx/run/mem/long/uns/ovf/fin", $realtime);
                    $display("  exp %0d %0d %0d %0d %0d %0d %0d", exp_r.index,
                             exp_r.run_length, exp_r.in_subsequence, exp_r.longest,
                             exp_r.unsorted_count, exp_r.overflow, exp_r.final_result);
                    $display("  got %0d %0d %0d %0d %0d %0d %0d", got.index,
                             got.run_length, got.in_subsequence, got.longest,
                             got.unsorted_count, got.overflow, got.final_result);
                end
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [VALUE_W-1:0]    s_value      = '0;
    logic                  s_final_item = 1'b0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [INDEX_W-1:0]    m_index;
    logic [RUN_W-1:0]      m_run_length;
    logic                  m_in_subsequence;
    logic [RUN_W-1:0]      m_longest;
    logic [UNSORTED_W-1:0] m_unsorted_count;
    logic                  m_overflow;
    logic                  m_final_result;

    lis_scoreboard lis_sb = new();

    int          items_sent  = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;
    int          ready_left  = 0;
    ready_mode_t ready_mode  = READY_ALWAYS;

    longest_increasing_subsequence uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_value          (s_value),
        .s_final_item     (s_final_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_index          (m_index),
        .m_run_length     (m_run_length),
        .m_in_subsequence (m_in_subsequence),
        .m_longest        (m_longest),
        .m_unsorted_count (m_unsorted_count),
        .m_overflow       (m_overflow),
        .m_final_result   (m_final_result)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Monitors: input transactions feed the predictor, results get checked
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            lis_sb.note_element(s_value, s_final_item);
        if (aresetn && m_valid && m_ready)
            lis_sb.check_result({m_index, m_run_length, m_in_subsequence, m_longest,
                                 m_unsorted_count, m_overflow, m_final_result});
    end

    // receiver: stall pattern switches to a random mode after each random-length stretch
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(0, 2));
            ready_left <= $urandom_range(20, 200);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS: m_ready <= 1'b1;
            READY_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
            default:      m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // watchdog: too long without any transaction ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    // one element; a gap opens at the end of each burst
    task automatic send_element(input logic [VALUE_W-1:0] key, input logic last);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        s_valid      <= 1'b1;
        s_value      <= key;
        s_final_item <= last;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_sequence(input int len, input key_shape_t shape);
        int unsigned key;
        int unsigned step;
        key  = (shape == KEYS_FALLING) ? 65535 - $urandom_range(0, 1000)
                                       : $urandom_range(0, 1000);
        step = $urandom_range(1, 900);
        for (int i = 0; i < len; i++) begin
            case (shape)
                KEYS_RANDOM: key = $urandom_range(0, 65535);
                KEYS_FEW:    key = $urandom_range(0, 7);
                KEYS_NOISY_RAMP: begin
                    if ($urandom_range(0, 3) == 0) key = $urandom_range(0, 65535);
                    else key = (key + $urandom_range(0, 50)) & 16'hFFFF;
                end
                KEYS_RISING:  if (i > 0) key = key + step;
                default:      if (i > 0) key = key - step;
            endcase
            send_element(key[VALUE_W-1:0], i == len - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int seq_count;
        int len;
        key_shape_t shape;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-element sequences at both key extremes
        send_element(16'h0000, 1'b1);
        send_element(16'hFFFF, 1'b1);
        // strictly falling: every run is one, the first element is the end
        send_element(16'd5, 1'b0);
        send_element(16'd4, 1'b0);
        send_element(16'd3, 1'b0);
        send_element(16'd2, 1'b0);
        send_element(16'd1, 1'b1);
        // equal keys never extend one another
        send_element(16'd7, 1'b0);
        send_element(16'd7, 1'b0);
        send_element(16'd7, 1'b1);
        // mixed order; walk must pick the nearest predecessor
        send_element(16'h0000, 1'b0);
        send_element(16'hFFFF, 1'b0);
        send_element(16'h8000, 1'b0);
        send_element(16'h0001, 1'b0);
        send_element(16'h0002, 1'b0);
        send_element(16'h0003, 1'b1);
        // strictly rising
        send_element(16'd10, 1'b0);
        send_element(16'd20, 1'b0);
        send_element(16'd30, 1'b0);
        send_element(16'd40, 1'b1);

        // random sequences; a full store, a fully dropped tail and a dropped
        // final element are placed among them
        seq_count = 0;
        while (items_sent < ITEM_TARGET) begin
            case (seq_count)
                2: begin
                    len   = LIS_MAX_LEN;
                    shape = KEYS_RISING;
                end
                5: begin
                    len   = LIS_MAX_LEN + 2;
                    shape = KEYS_FALLING;
                end
                8: begin
                    len   = LIS_MAX_LEN + 1;
                    shape = KEYS_NOISY_RAMP;
                end
                default: begin
                    len   = $urandom_range(1, 12);
                    shape = key_shape_t'($urandom_range(0, 4));
                end
            endcase
            send_sequence(len, shape);
            seq_count++;
        end
        s_valid <= 1'b0;

        // drain outstanding results, then watch for stray ones
        while (lis_sb.owed_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (lis_sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
design/lis_pkg.sv
design/lis_ctrl.sv
design/lis_dp.sv
design/longest_increasing_subsequence.sv
test/tb.sv
